/* rtl/tpc_pkg.sv */
// shared types, register map and fixed-point helpers for the pose calibration block
package tpc_pkg;

   // configuration map, one 64-bit slot per register
   localparam int unsigned CsrAddrWidth = 6;
   localparam int unsigned CsrDataWidth = 64;

   localparam logic [2:0] RegCalRow0    = 3'd0;
   localparam logic [2:0] RegCalRow1    = 3'd1;
   localparam logic [2:0] RegCalRow2    = 3'd2;
   localparam logic [2:0] RegOffsetX    = 3'd3;
   localparam logic [2:0] RegOffsetY    = 3'd4;
   localparam logic [2:0] RegOffsetZ    = 3'd5;
   localparam logic [2:0] RegCalibrated = 3'd6;

   typedef logic signed [15:0] q115_type;
   typedef logic signed [15:0] q214_type;
   typedef logic signed [31:0] q1616_type;

   localparam q214_type CalOne = 16'sh4000;

   // calibration state as seen by the datapath
   typedef struct packed {
      q214_type [2:0][2:0] cal;     // [row][column]
      q1616_type [2:0]     offset;  // x, y, z
      logic                calibrated;
   } cfg_type;

   // one pose travelling between the matrix builder and the calibration stages
   typedef struct packed {
      q1616_type [2:0]     pos;
      q214_type [2:0][2:0] rot;     // [row][column]
      logic                use_cal;
   } pose_type;

   // Q2.30 sum to Q2.14: round half up, floor shift by 16, saturate
   function automatic q214_type round_q230(input logic signed [34:0] v);
      logic signed [34:0] t;
      logic signed [18:0] s;
      t = v + 35'sd32768;
      s = 19'(t >>> 16);
      if (s > 19'sd32767) begin
         return 16'sh7fff;
      end else if (s < -19'sd32768) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   // Q4.28 matrix product sum to Q2.14: round, floor shift by 14, saturate
   function automatic q214_type round_q428(input logic signed [33:0] v);
      logic signed [33:0] t;
      logic signed [19:0] s;
      t = v + 34'sd8192;
      s = 20'(t >>> 14);
      if (s > 20'sd32767) begin
         return 16'sh7fff;
      end else if (s < -20'sd32768) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   // Q2.14 x Q16.16 sum back to Q16.16, kept wide for the offset add
   function automatic logic signed [35:0] round_pos(input logic signed [49:0] v);
      logic signed [49:0] t;
      t = v + 50'sd8192;
      return 36'(t >>> 14);
   endfunction

   // saturate a widened position to Q16.16
   function automatic q1616_type sat_pos(input logic signed [36:0] v);
      if (v > 37'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -37'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

/* rtl/tracker_pose_calibration_unit.sv */
// top level of the tracker pose calibration block
//
//   channel   direction   handshake                 carries
//   req_      in          req_valid / req_stall     position Q16.16, quaternion Q1.15, flag
//   rsp_      out         rsp_valid / rsp_stall     position Q16.16, 3x3 matrix Q2.14
//   apb       in/out      psel / penable / pready   calibration rows, offsets, enable
//
// five register stages from req to rsp: a transaction taken on req passes through them
// in order and is held on rsp by the last; one transaction per cycle sustained while rsp
// is not stalled, as each stage loads whenever it is empty or the stage after it loads
// reset is synchronous; it empties the pipe and loads the identity calibration
// a stall on rsp holds the output register; earlier stages keep filling bubbles and
// req_stall rises only once every stage is occupied
// configuration is expected to change only while the pipe is empty
module tracker_pose_calibration_unit (
   input  logic                                clock,
   input  logic                                reset,
   // sample in
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [31:0]                  req_pos_x,
   input  logic signed [31:0]                  req_pos_y,
   input  logic signed [31:0]                  req_pos_z,
   input  logic signed [15:0]                  req_quat_x,
   input  logic signed [15:0]                  req_quat_y,
   input  logic signed [15:0]                  req_quat_z,
   input  logic signed [15:0]                  req_quat_w,
   input  logic                                req_use_calibration,
   // pose out
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_out_pos_x,
   output logic signed [31:0]                  rsp_out_pos_y,
   output logic signed [31:0]                  rsp_out_pos_z,
   output logic signed [15:0]                  rsp_rot_00,
   output logic signed [15:0]                  rsp_rot_01,
   output logic signed [15:0]                  rsp_rot_02,
   output logic signed [15:0]                  rsp_rot_10,
   output logic signed [15:0]                  rsp_rot_11,
   output logic signed [15:0]                  rsp_rot_12,
   output logic signed [15:0]                  rsp_rot_20,
   output logic signed [15:0]                  rsp_rot_21,
   output logic signed [15:0]                  rsp_rot_22,
   // configuration
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tpc_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [tpc_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [tpc_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready
);
   import tpc_pkg::*;

   cfg_type         cfg;
   q1616_type [2:0] req_pos;
   pose_type        mid_pose;
   logic            mid_valid;
   logic            mid_stall;
   pose_type        rsp_pose;

   // position components gathered as x, y, z
   assign req_pos[0] = req_pos_x;
   assign req_pos[1] = req_pos_y;
   assign req_pos[2] = req_pos_z;

   // register file, read back combinationally
   tpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // stages 1-2: quaternion products, then sums rounded to Q2.14
   tpc_rot_build u_rot_build (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_pos     (req_pos),
      .in_quat_x  (req_quat_x),
      .in_quat_y  (req_quat_y),
      .in_quat_z  (req_quat_z),
      .in_quat_w  (req_quat_w),
      .in_use_cal (req_use_calibration),
      .out_valid  (mid_valid),
      .out_stall  (mid_stall),
      .out_pose   (mid_pose)
   );

   // stages 3-5: calibration products, sums, offset and selection
   tpc_cal_apply u_cal_apply (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mid_valid),
      .in_stall  (mid_stall),
      .in_pose   (mid_pose),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_pose  (rsp_pose)
   );

   assign rsp_out_pos_x = rsp_pose.pos[0];
   assign rsp_out_pos_y = rsp_pose.pos[1];
   assign rsp_out_pos_z = rsp_pose.pos[2];
   assign rsp_rot_00    = rsp_pose.rot[0][0];
   assign rsp_rot_01    = rsp_pose.rot[0][1];
   assign rsp_rot_02    = rsp_pose.rot[0][2];
   assign rsp_rot_10    = rsp_pose.rot[1][0];
   assign rsp_rot_11    = rsp_pose.rot[1][1];
   assign rsp_rot_12    = rsp_pose.rot[1][2];
   assign rsp_rot_20    = rsp_pose.rot[2][0];
   assign rsp_rot_21    = rsp_pose.rot[2][1];
   assign rsp_rot_22    = rsp_pose.rot[2][2];

endmodule

/* rtl/tpc_csr.sv */
// configuration register file with apb-style access
module tpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tpc_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [tpc_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [tpc_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready,
   output tpc_pkg::cfg_type                    cfg
);
   import tpc_pkg::*;

   q214_type [2:0][2:0] cal_ff;
   q1616_type [2:0]     offset_ff;
   logic                calibrated_ff;
   logic [2:0]          index;
   logic                wr;

   assign pready = 1'b1;
   assign index  = paddr[CsrAddrWidth-1:3];
   assign wr     = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               cal_ff[i][j] <= (i == j) ? CalOne : '0;
            end
            offset_ff[i] <= '0;
         end
         calibrated_ff <= 1'b0;
      end else if (wr) begin
         case (index)
            RegCalRow0:    cal_ff[0]     <= pwdata[47:0];
            RegCalRow1:    cal_ff[1]     <= pwdata[47:0];
            RegCalRow2:    cal_ff[2]     <= pwdata[47:0];
            RegOffsetX:    offset_ff[0]  <= pwdata[31:0];
            RegOffsetY:    offset_ff[1]  <= pwdata[31:0];
            RegOffsetZ:    offset_ff[2]  <= pwdata[31:0];
            RegCalibrated: calibrated_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         RegCalRow0:    prdata = {16'b0, cal_ff[0]};
         RegCalRow1:    prdata = {16'b0, cal_ff[1]};
         RegCalRow2:    prdata = {16'b0, cal_ff[2]};
         RegOffsetX:    prdata = {32'b0, offset_ff[0]};
         RegOffsetY:    prdata = {32'b0, offset_ff[1]};
         RegOffsetZ:    prdata = {32'b0, offset_ff[2]};
         RegCalibrated: prdata = {63'b0, calibrated_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.cal        = cal_ff;
   assign cfg.offset     = offset_ff;
   assign cfg.calibrated = calibrated_ff;

endmodule

/* rtl/tpc_rot_build.sv */
// two-stage quaternion to rotation matrix builder
module tpc_rot_build (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_stall,
   input  tpc_pkg::q1616_type [2:0]   in_pos,
   input  tpc_pkg::q115_type          in_quat_x,
   input  tpc_pkg::q115_type          in_quat_y,
   input  tpc_pkg::q115_type          in_quat_z,
   input  tpc_pkg::q115_type          in_quat_w,
   input  logic                       in_use_cal,
   output logic                       out_valid,
   input  logic                       out_stall,
   output tpc_pkg::pose_type          out_pose
);
   import tpc_pkg::*;

   logic [1:0] v_ff;
   logic [1:0] en;

   // stage a: the ten quaternion products, exact in Q2.30
   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;
   q1616_type [2:0]    pos_ff;
   logic               use_ff;

   // stage b: rounded matrix
   logic signed [34:0] sum [2:0][2:0];
   pose_type           pose_ff;

   assign en[1]    = !v_ff[1] || !out_stall;
   assign en[0]    = !v_ff[0] || en[1];
   assign in_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         if (en[1]) begin
            v_ff[1] <= v_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         xx_ff  <= in_quat_x * in_quat_x;
         yy_ff  <= in_quat_y * in_quat_y;
         zz_ff  <= in_quat_z * in_quat_z;
         ww_ff  <= in_quat_w * in_quat_w;
         xy_ff  <= in_quat_x * in_quat_y;
         zw_ff  <= in_quat_z * in_quat_w;
         xz_ff  <= in_quat_x * in_quat_z;
         yw_ff  <= in_quat_y * in_quat_w;
         yz_ff  <= in_quat_y * in_quat_z;
         xw_ff  <= in_quat_x * in_quat_w;
         pos_ff <= in_pos;
         use_ff <= in_use_cal;
      end
   end

   always_comb begin
      sum[0][0] = 35'(xx_ff) + 35'(ww_ff) - 35'(zz_ff) - 35'(yy_ff);
      sum[1][1] = 35'(yy_ff) - 35'(xx_ff) + 35'(ww_ff) - 35'(zz_ff);
      sum[2][2] = 35'(zz_ff) - 35'(yy_ff) - 35'(xx_ff) + 35'(ww_ff);
      sum[0][1] = (35'(xy_ff) - 35'(zw_ff)) <<< 1;
      sum[0][2] = (35'(xz_ff) + 35'(yw_ff)) <<< 1;
      sum[1][0] = (35'(xy_ff) + 35'(zw_ff)) <<< 1;
      sum[1][2] = (35'(yz_ff) - 35'(xw_ff)) <<< 1;
      sum[2][0] = (35'(xz_ff) - 35'(yw_ff)) <<< 1;
      sum[2][1] = (35'(yz_ff) + 35'(xw_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pose_ff.rot[i][j] <= round_q230(sum[i][j]);
            end
         end
         pose_ff.pos     <= pos_ff;
         pose_ff.use_cal <= use_ff;
      end
   end

   assign out_valid = v_ff[1];
   assign out_pose  = pose_ff;

endmodule

/* rtl/tpc_cal_apply.sv */
// three-stage calibration rotation and offset stage
module tpc_cal_apply (
   input  logic                 clock,
   input  logic                 reset,
   input  tpc_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  tpc_pkg::pose_type    in_pose,
   output logic                 out_valid,
   input  logic                 out_stall,
   output tpc_pkg::pose_type    out_pose
);
   import tpc_pkg::*;

   logic [2:0] v_ff;
   logic [2:0] en;

   // stage 1: products, matrix [i][j][k] and position [i][k]
   logic signed [31:0] mp_in [2:0][2:0][2:0];
   logic signed [47:0] pp_in [2:0][2:0];
   logic signed [31:0] mp_ff [2:0][2:0][2:0];
   logic signed [47:0] pp_ff [2:0][2:0];
   pose_type           pose1_ff;
   logic               apply1_ff;

   // stage 2: sums, rounded
   q214_type [2:0][2:0] mat_ff;
   logic signed [35:0]  prnd_ff [2:0];
   pose_type            pose2_ff;
   logic                apply2_ff;

   // stage 3: offset add, saturate, select
   pose_type            pose3_ff;

   assign en[2]    = !v_ff[2] || !out_stall;
   assign en[1]    = !v_ff[1] || en[2];
   assign en[0]    = !v_ff[0] || en[1];
   assign in_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         if (en[1]) begin
            v_ff[1] <= v_ff[0];
         end
         if (en[2]) begin
            v_ff[2] <= v_ff[1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            pp_in[i][k] = cfg.cal[i][k] * in_pose.pos[k];
            for (int j = 0; j < 3; j++) begin
               mp_in[i][j][k] = cfg.cal[i][k] * in_pose.rot[k][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mp_ff     <= mp_in;
         pp_ff     <= pp_in;
         pose1_ff  <= in_pose;
         apply1_ff <= in_pose.use_cal && cfg.calibrated;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               mat_ff[i][j] <= round_q428(34'(mp_ff[i][j][0]) + 34'(mp_ff[i][j][1])
                                          + 34'(mp_ff[i][j][2]));
            end
            prnd_ff[i] <= round_pos(50'(pp_ff[i][0]) + 50'(pp_ff[i][1]) + 50'(pp_ff[i][2]));
         end
         pose2_ff  <= pose1_ff;
         apply2_ff <= apply1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         if (apply2_ff) begin
            for (int i = 0; i < 3; i++) begin
               pose3_ff.pos[i] <= sat_pos(37'(prnd_ff[i]) + 37'(cfg.offset[i]));
            end
            pose3_ff.rot <= mat_ff;
         end else begin
            pose3_ff.pos <= pose2_ff.pos;
            pose3_ff.rot <= pose2_ff.rot;
         end
         pose3_ff.use_cal <= apply2_ff;
      end
   end

   assign out_valid = v_ff[2];
   assign out_pose  = pose3_ff;

endmodule

/* rtl/tpc_checker.sv */
// port-level checks for the pose calibration block, bound to the top level
module tpc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [31:0]                  rsp_out_pos_x,
   input logic signed [15:0]                  rsp_rot_00,
   input logic                                psel,
   input logic                                penable,
   input logic                                pwrite,
   input logic [tpc_pkg::CsrAddrWidth-1:0]    paddr,
   input logic [tpc_pkg::CsrDataWidth-1:0]    pwdata,
   input logic [tpc_pkg::CsrDataWidth-1:0]    prdata
);
   import tpc_pkg::*;

   logic       wr;
   logic [2:0] index;

   assign wr    = psel && penable && pwrite;
   assign index = paddr[CsrAddrWidth-1:3];

   // a stalled transaction stays and keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_pos_x) && $stable(rsp_rot_00))
      else $error("stalled result changed");

   // reset leaves the pipe empty
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // enable register reads back a single bit
   assert property (@(posedge clock)
      psel && !pwrite && index == RegCalibrated |-> prdata[CsrDataWidth-1:1] == '0)
      else $error("calibrated read has stray bits");

   // a write to a row or offset shows in the low 32 bits of a read of the same register that directly follows it
   assert property (@(posedge clock) disable iff (reset)
      wr && (index == RegCalRow0 || index == RegCalRow1 || index == RegCalRow2 ||
             index == RegOffsetX || index == RegOffsetY || index == RegOffsetZ)
      |=> !(psel && !pwrite && index == $past(index)) || prdata[31:0] == $past(pwdata[31:0]))
      else $error("register read-back mismatch");

endmodule

bind tracker_pose_calibration_unit tpc_checker u_tpc_checker (.*);
